FILE: rtl/nsc_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and register codes of the separable convolution filter.
package nsc_pkg;

  localparam int PIX_W     = 8;
  localparam int WGT_W     = 8;
  localparam int IMG_W_W   = 12;
  localparam int IMG_H_W   = 13;
  localparam int KER_W     = 3;
  localparam int WGTS_W    = 56;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 56;

  // Arithmetic widths for a window of up to 7 x 7 taps with 8-bit weights.
  localparam int WPROD_W = 2 * WGT_W;
  localparam int SUM_W   = 30;
  localparam int TOT_W   = 22;
  localparam int NUM_W   = SUM_W + 1;
  localparam int DEN_W   = TOT_W + 1;
  localparam int QUO_W   = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_WEIGHTS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WEIGHTS    = 3'd5;

  localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [IMG_H_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [KER_W-1:0]   RST_KERNEL       = 3'd3;
  localparam logic [WGTS_W-1:0]  RST_WEIGHTS      = 56'h00000000010201;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             is_flush;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             end_of_frame;
    logic             zero_weight;
  } pix_out_t;

  typedef struct packed {
    logic [IMG_W_W-1:0] image_width;
    logic [IMG_H_W-1:0] image_height;
    logic [KER_W-1:0]   kernel_height;
    logic [KER_W-1:0]   kernel_width;
    logic [WGTS_W-1:0]  column_weights;
    logic [WGTS_W-1:0]  row_weights;
  } cfg_t;

  // Half kernel size before the storage limit; even sizes round down.
  function automatic logic [1:0] half_raw(input logic [KER_W-1:0] k);
    logic [KER_W-1:0] km1;
    km1 = k - 3'd1;
    return (k == '0) ? 2'd0 : km1[2:1];
  endfunction

endpackage

FILE: rtl/normalized_separable_image_convolution.sv
`timescale 1ns / 1ps
// Top level of the normalized separable image convolution filter.
//
//  channel   handshake              payload
//  -------   --------------------   ------------------------------------------
//  input     push / full            in_data_i  : pixel_in, is_flush
//  result    empty / pop            out_data_o : pixel_out, end_of_frame, zero_weight
//  config    cfg_valid_i / ready    cfg_index_i, cfg_data_i (ready always high)
//
// A pixel that yields no result stays in ST_IDLE. A border result passes
// ST_BRD_RD, ST_BRD_WAIT and ST_PUSH; a filtered one passes ST_MAC, ST_DRAIN,
// ST_DSTART, ST_DIV (skipped at zero total weight) and ST_PUSH, set by the single
// line store read port (one tap per cycle) and divider (one quotient bit per cycle).
// Two-entry queues on both sides let input and output stall independently.
// Reset clears counters and queues; the line store is not cleared.
module normalized_separable_image_convolution import nsc_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_KERNEL = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  input  pix_in_t              in_data_i,
  output logic                 full,
  output logic                 empty,
  input  logic                 pop,
  output pix_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  cfg_t     cfg_q;
  pix_in_t  item;
  pix_out_t res;
  logic     in_empty, item_take, res_full, res_push;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width    <= RST_IMAGE_WIDTH;
      cfg_q.image_height   <= RST_IMAGE_HEIGHT;
      cfg_q.kernel_height  <= RST_KERNEL;
      cfg_q.kernel_width   <= RST_KERNEL;
      cfg_q.column_weights <= RST_WEIGHTS;
      cfg_q.row_weights    <= RST_WEIGHTS;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:    cfg_q.image_width    <= cfg_data_i[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT:   cfg_q.image_height   <= cfg_data_i[IMG_H_W-1:0];
        CFG_KERNEL_HEIGHT:  cfg_q.kernel_height  <= cfg_data_i[KER_W-1:0];
        CFG_KERNEL_WIDTH:   cfg_q.kernel_width   <= cfg_data_i[KER_W-1:0];
        CFG_COLUMN_WEIGHTS: cfg_q.column_weights <= cfg_data_i[WGTS_W-1:0];
        CFG_ROW_WEIGHTS:    cfg_q.row_weights    <= cfg_data_i[WGTS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  nsc_fifo #(.item_t(pix_in_t), .Depth(2)) u_in_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (in_data_i),
    .full_o  (full),
    .pop_i   (item_take),
    .data_o  (item),
    .empty_o (in_empty)
  );

  nsc_back #(.MaxWidth(MAX_WIDTH), .MaxKernel(MAX_KERNEL)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (!in_empty),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  nsc_fifo #(.item_t(pix_out_t), .Depth(2)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_data_o),
    .empty_o (empty)
  );

  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full) else $error("result pushed into full queue");

  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take |-> !in_empty) else $error("engine took from empty input queue");

  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res.zero_weight) |-> (res.pixel_out == '0))
    else $error("zero weight result carries nonzero pixel");

endmodule

FILE: rtl/nsc_fifo.sv
`timescale 1ns / 1ps
// Small first-in first-out queue used on both sides of the filter engine.
module nsc_fifo #(
  parameter type item_t = logic,
  parameter int  Depth  = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/nsc_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the normalization step.
module nsc_div import nsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);

  localparam int CntW = $clog2(QUO_W);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [NUM_W-1:0] rem_q, trial;
  logic [DEN_W-1:0] den_q;
  logic [QUO_W-1:0] quo_q;
  logic             ge;

  // The quotient never exceeds QUO_W bits since the sum is at most 255 * total.
  assign trial  = NUM_W'(den_q) << cnt_q;
  assign ge     = (rem_q >= trial);
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QUO_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - trial;
      end
      quo_q[cnt_q] <= ge;
    end
  end

endmodule

FILE: rtl/nsc_back.sv
`timescale 1ns / 1ps
// Filter engine: line store, position counters, tap sequencer and normalization.
module nsc_back import nsc_pkg::*; #(
  parameter int MaxWidth  = 2048,
  parameter int MaxKernel = 7
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     item_valid_i,
  input  pix_in_t  item_i,
  output logic     item_take_o,
  input  logic     res_full_i,
  output logic     res_push_o,
  output pix_out_t res_o
);

  localparam int HalfLim = ((MaxKernel - 1) / 2 > 3) ? 3 : (MaxKernel - 1) / 2;
  localparam int Depth   = MaxKernel * MaxWidth;
  localparam int CW      = $clog2(MaxWidth);
  localparam int WW      = $clog2(MaxWidth + 1);
  localparam int SW      = $clog2(MaxKernel);
  localparam int AW      = $clog2(Depth);
  localparam int PW      = $clog2(3 * MaxWidth + 5);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MAC      = 3'd1;
  localparam logic [2:0] ST_DRAIN    = 3'd2;
  localparam logic [2:0] ST_DSTART   = 3'd3;
  localparam logic [2:0] ST_DIV      = 3'd4;
  localparam logic [2:0] ST_BRD_RD   = 3'd5;
  localparam logic [2:0] ST_BRD_WAIT = 3'd6;
  localparam logic [2:0] ST_PUSH     = 3'd7;

  logic [PIX_W-1:0]   mem [Depth];
  logic [PIX_W-1:0]   rd_q;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;

  logic [2:0]         state_q, state_d;
  logic [CW-1:0]      in_col_q, in_col_d, out_col_q, out_col_d, rd_col_q, rd_col_d;
  logic [IMG_H_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [SW-1:0]      in_slot_q, in_slot_d, out_slot_q, out_slot_d, rd_slot_q, rd_slot_d;
  logic [PW-1:0]      pend_q, pend_d;
  logic [2:0]         ti_q, ti_d, tj_q, tj_d;
  logic [SUM_W-1:0]   acc_q, acc_d;
  logic [TOT_W-1:0]   tot_q, tot_d;
  logic [WPROD_W-1:0] wprod_q, wprod_d;
  logic               pv_q, pv_d;
  pix_out_t           res_q, res_d;

  logic [WW-1:0]      w;
  logic [IMG_H_W-1:0] h;
  logic [1:0]         hh, hw, hh_raw, hw_raw;
  logic [PW-1:0]      lat;
  logic               interior, eof, go_out;
  logic [SW-1:0]      start_slot;
  logic [WGT_W-1:0]   cw_sel, rw_sel;
  logic [23:0]        prod;
  logic               div_start, div_done;
  logic [QUO_W-1:0]   quo;

  function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] s, input logic [CW-1:0] col);
    return AW'(s) * AW'(MaxWidth) + AW'(col);
  endfunction

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(MaxKernel - 1)) ? '0 : s + 1'b1;
  endfunction

  // Effective geometry
  always_comb begin
    if (cfg_i.image_width == '0) begin
      w = WW'(1);
    end else if (32'(cfg_i.image_width) > MaxWidth) begin
      w = WW'(MaxWidth);
    end else begin
      w = WW'(cfg_i.image_width);
    end
    h      = (cfg_i.image_height == '0) ? IMG_H_W'(1) : cfg_i.image_height;
    hh_raw = half_raw(cfg_i.kernel_height);
    hw_raw = half_raw(cfg_i.kernel_width);
    hh     = (32'(hh_raw) > HalfLim) ? 2'(HalfLim) : hh_raw;
    hw     = (32'(hw_raw) > HalfLim) ? 2'(HalfLim) : hw_raw;
    lat    = PW'(hh) * PW'(w) + PW'(hw);
  end

  assign interior = (32'(out_row_q) >= 32'(hh)) && (32'(out_row_q) + 32'(hh) < 32'(h)) &&
                    (32'(out_col_q) >= 32'(hw)) && (32'(out_col_q) + 32'(hw) < 32'(w));
  assign eof = (32'(out_row_q) == 32'(h) - 32'd1) && (32'(out_col_q) == 32'(w) - 32'd1);
  assign start_slot = (32'(out_slot_q) >= 32'(hh)) ? out_slot_q - SW'(hh)
                                                   : out_slot_q + SW'(MaxKernel) - SW'(hh);

  assign cw_sel = cfg_i.column_weights[{ti_q, 3'b000} +: WGT_W];
  assign rw_sel = cfg_i.row_weights[{tj_q, 3'b000} +: WGT_W];
  assign prod   = 24'(rd_q) * 24'(wprod_q);

  assign wr_addr = addr_of(in_slot_q, in_col_q);

  always_comb begin
    state_d     = state_q;
    in_col_d    = in_col_q;
    in_row_d    = in_row_q;
    in_slot_d   = in_slot_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_slot_d  = out_slot_q;
    rd_col_d    = rd_col_q;
    rd_slot_d   = rd_slot_q;
    pend_d      = pend_q;
    ti_d        = ti_q;
    tj_d        = tj_q;
    acc_d       = acc_q;
    tot_d       = tot_q;
    wprod_d     = wprod_q;
    pv_d        = 1'b0;
    res_d       = res_q;
    rd_en       = 1'b0;
    rd_addr     = addr_of(rd_slot_q, rd_col_q);
    wr_en       = 1'b0;
    item_take_o = 1'b0;
    res_push_o  = 1'b0;
    div_start   = 1'b0;
    go_out      = 1'b0;

    // product stage accumulates the read data in the cycle after the read
    if (pv_q) begin
      acc_d = acc_q + SUM_W'(prod);
      tot_d = tot_q + TOT_W'(wprod_q);
    end

    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_take_o = 1'b1;
          if (!item_i.is_flush) begin
            wr_en = 1'b1;
            if (32'(in_col_q) + 32'd1 >= 32'(w)) begin
              in_col_d  = '0;
              in_slot_d = slot_inc(in_slot_q);
              in_row_d  = (32'(in_row_q) + 32'd1 >= 32'(h)) ? '0 : in_row_q + 1'b1;
            end else begin
              in_col_d = in_col_q + 1'b1;
            end
            if (32'(pend_q) + 32'd1 <= 32'(lat)) begin
              pend_d = pend_q + 1'b1;
            end else begin
              go_out = 1'b1;
            end
          end else if (pend_q != '0) begin
            pend_d = pend_q - 1'b1;
            go_out = 1'b1;
          end
        end
        if (go_out) begin
          res_d.end_of_frame = eof;
          res_d.zero_weight  = 1'b0;
          res_d.pixel_out    = '0;
          if (interior) begin
            ti_d      = '0;
            tj_d      = '0;
            rd_col_d  = out_col_q - CW'(hw);
            rd_slot_d = start_slot;
            acc_d     = '0;
            tot_d     = '0;
            state_d   = ST_MAC;
          end else begin
            state_d = ST_BRD_RD;
          end
        end
      end
      ST_MAC: begin
        rd_en   = 1'b1;
        wprod_d = WPROD_W'(cw_sel) * WPROD_W'(rw_sel);
        pv_d    = 1'b1;
        if (tj_q == {hw, 1'b0}) begin
          tj_d      = '0;
          rd_col_d  = out_col_q - CW'(hw);
          rd_slot_d = slot_inc(rd_slot_q);
          ti_d      = ti_q + 1'b1;
          if (ti_q == {hh, 1'b0}) begin
            state_d = ST_DRAIN;
          end
        end else begin
          tj_d     = tj_q + 1'b1;
          rd_col_d = rd_col_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DSTART;
      end
      ST_DSTART: begin
        if (tot_q == '0) begin
          res_d.zero_weight = 1'b1;
          res_d.pixel_out   = '0;
          state_d           = ST_PUSH;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_d.pixel_out = quo[QUO_W-1] ? '1 : quo[PIX_W-1:0];
          state_d         = ST_PUSH;
        end
      end
      ST_BRD_RD: begin
        rd_en   = 1'b1;
        rd_addr = addr_of(out_slot_q, out_col_q);
        state_d = ST_BRD_WAIT;
      end
      ST_BRD_WAIT: begin
        res_d.pixel_out = rd_q;
        state_d         = ST_PUSH;
      end
      ST_PUSH: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (32'(out_col_q) + 32'd1 >= 32'(w)) begin
            out_col_d  = '0;
            out_slot_d = slot_inc(out_slot_q);
            out_row_d  = (32'(out_row_q) + 32'd1 >= 32'(h)) ? '0 : out_row_q + 1'b1;
          end else begin
            out_col_d = out_col_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  nsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({acc_q, 1'b0} + NUM_W'(tot_q)),
    .den_i   ({tot_q, 1'b0}),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
      pend_q     <= '0;
      pv_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_slot_q  <= in_slot_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_slot_q <= out_slot_d;
      pend_q     <= pend_d;
      pv_q       <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_col_q  <= rd_col_d;
    rd_slot_q <= rd_slot_d;
    ti_q      <= ti_d;
    tj_q      <= tj_d;
    acc_q     <= acc_d;
    tot_q     <= tot_d;
    wprod_q   <= wprod_d;
    res_q     <= res_d;
  end

  // Line store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= item_i.pixel_in;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

endmodule

FILE: verif/normalized_separable_image_convolution_test.sv
`timescale 1ns / 1ps
// Self-checking testbench: streams frames through the convolution filter and checks every pixel.
module normalized_separable_image_convolution_test;
  import nsc_pkg::*;

  localparam int STORE_W    = 2048;
  localparam int STORE_ROWS = 7;
  localparam int RAND_ITEMS = 800;
  localparam int DRAIN_WAIT = 120;
  localparam longint CYCLE_LIMIT = 6000000;

  typedef struct {
    logic [7:0] pix;
    bit         flush;
    bit         typed;
    pix_out_t   res;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 push = 1'b0;
  pix_in_t              in_data_i = '0;
  logic                 full, empty;
  logic                 pop = 1'b0;
  pix_out_t             out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  normalized_separable_image_convolution i_dut (.*);

  always #10 clk_i = ~clk_i;

  // Filter model state
  logic [7:0]         line_mem [STORE_ROWS*STORE_W];
  int unsigned        in_col, in_row, out_col, out_row, in_slot, out_slot, backlog;
  logic [IMG_W_W-1:0] m_width = RST_IMAGE_WIDTH;
  logic [IMG_H_W-1:0] m_height = RST_IMAGE_HEIGHT;
  logic [KER_W-1:0]   m_kh = RST_KERNEL, m_kw = RST_KERNEL;
  logic [WGTS_W-1:0]  m_colw = RST_WEIGHTS, m_roww = RST_WEIGHTS;

  pix_out_t    pixel_queue[$];
  int          errors = 0;
  longint      cycles = 0;
  bit          idle_on = 1'b1;
  int unsigned rand_sent = 0;

  function automatic int unsigned half_size(logic [KER_W-1:0] k);
    int unsigned h;
    h = (k == 0) ? 0 : (k - 1) / 2;
    return (h > 3) ? 3 : h;
  endfunction

  function automatic int unsigned tap_weight(logic [WGTS_W-1:0] w, int unsigned t);
    return (w >> (8 * t)) & 8'hFF;
  endfunction

  function automatic int unsigned frame_w();
    if (m_width == 0) return 1;
    return (m_width > STORE_W) ? STORE_W : m_width;
  endfunction

  function automatic int unsigned frame_h();
    return (m_height == 0) ? 1 : m_height;
  endfunction

  function automatic logic [7:0] stored_px(int dk, int unsigned c);
    int unsigned slot;
    slot = (int'(out_slot) + 8 * STORE_ROWS + dk) % STORE_ROWS;
    return line_mem[slot * STORE_W + (c % STORE_W)];
  endfunction

  task automatic step_pos(inout int unsigned c, inout int unsigned r, inout int unsigned s);
    c++;
    if (c >= frame_w()) begin
      c = 0;
      s = (s + 1) % STORE_ROWS;
      r++;
      if (r >= frame_h()) r = 0;
    end
  endtask

  task automatic filter_pixel(input pix_in_t it, output bit has, output pix_out_t res);
    int unsigned w, h, hh, hw, r, c;
    longint unsigned acc, csum, rsum, total, q;
    w = frame_w();
    h = frame_h();
    hh = half_size(m_kh);
    hw = half_size(m_kw);
    has = 1'b0;
    res = '0;
    if (!it.is_flush) begin
      line_mem[in_slot * STORE_W + (in_col % STORE_W)] = it.pixel_in;
      step_pos(in_col, in_row, in_slot);
      backlog++;
      if (backlog <= hh * w + hw) return;
    end else if (backlog == 0) begin
      return;
    end
    backlog--;
    has = 1'b1;
    r = out_row;
    c = out_col;
    if (r >= hh && r + hh < h && c >= hw && c + hw < w) begin
      acc = 0; csum = 0; rsum = 0;
      for (int i = 0; i <= 2 * hh; i++) csum += tap_weight(m_colw, i);
      for (int j = 0; j <= 2 * hw; j++) rsum += tap_weight(m_roww, j);
      for (int i = 0; i <= 2 * hh; i++)
        for (int j = 0; j <= 2 * hw; j++)
          acc += longint'(stored_px(i - int'(hh), c + j - hw)) * tap_weight(m_colw, i)
                 * tap_weight(m_roww, j);
      total = csum * rsum;
      if (total == 0) begin
        res.zero_weight = 1'b1;
      end else begin
        q = (2 * acc + total) / (2 * total);
        res.pixel_out = (q > 255) ? 8'hFF : q[7:0];
      end
    end else begin
      res.pixel_out = stored_px(0, c);
    end
    res.end_of_frame = (r == h - 1 && c == w - 1);
    step_pos(out_col, out_row, out_slot);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_IMAGE_WIDTH:    m_width = val[IMG_W_W-1:0];
      CFG_IMAGE_HEIGHT:   m_height = val[IMG_H_W-1:0];
      CFG_KERNEL_HEIGHT:  m_kh = val[KER_W-1:0];
      CFG_KERNEL_WIDTH:   m_kw = val[KER_W-1:0];
      CFG_COLUMN_WEIGHTS: m_colw = val[WGTS_W-1:0];
      CFG_ROW_WEIGHTS:    m_roww = val[WGTS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setup(int unsigned w, int unsigned h, int unsigned kh, int unsigned kw,
                            logic [WGTS_W-1:0] cw, logic [WGTS_W-1:0] rw);
    write_reg(CFG_IMAGE_WIDTH, CFG_DAT_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DAT_W'(h));
    write_reg(CFG_KERNEL_HEIGHT, CFG_DAT_W'(kh));
    write_reg(CFG_KERNEL_WIDTH, CFG_DAT_W'(kw));
    write_reg(CFG_COLUMN_WEIGHTS, cw);
    write_reg(CFG_ROW_WEIGHTS, rw);
    cfg_valid_i <= 1'b0;
  endtask

  // typed: the result caused by this item is the given one rather than the model's
  task automatic send_pixel(pix_in_t it, bit typed = 1'b0, pix_out_t typed_res = '0);
    int unsigned gap;
    bit has;
    pix_out_t res;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (full);
    filter_pixel(it, has, res);
    if (has) pixel_queue.push_back(typed ? typed_res : res);
  endtask

  task automatic wait_idle();
    while (pixel_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [WGTS_W-1:0] random_weights(int mode);
    logic [WGTS_W-1:0] v;
    v = '0;
    for (int t = 0; t < 7; t++)
      if (mode == 0 || $urandom_range(0, 3) != 0)
        v[8*t +: 8] = 8'($urandom_range(0, 255));
    return v;
  endfunction

  // Result side: random stalls, check each transfer against the oldest expectation
  initial begin
    int unsigned gap;
    pix_out_t want;
    @(posedge rst_ni);
    forever begin
      gap = idle_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if (pixel_queue.size() == 0) begin
        $error("unexpected result pixel_out=%0d", out_data_o.pixel_out);
        errors++;
      end else begin
        want = pixel_queue.pop_front();
        if (out_data_o.pixel_out !== want.pixel_out) begin
          $error("pixel_out expected %0d got %0d", want.pixel_out, out_data_o.pixel_out);
          errors++;
        end
        if (out_data_o.end_of_frame !== want.end_of_frame) begin
          $error("end_of_frame expected %0d got %0d", want.end_of_frame,
                 out_data_o.end_of_frame);
          errors++;
        end
        if (out_data_o.zero_weight !== want.zero_weight) begin
          $error("zero_weight expected %0d got %0d", want.zero_weight,
                 out_data_o.zero_weight);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    int unsigned n_frames, n_pix, extra, w, h;
    pix_in_t it;
    int phase;
    for (int i = 0; i < STORE_ROWS * STORE_W; i++) line_mem[i] = '0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    in_slot = 0; out_slot = 0; backlog = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3x3 frame, 3x3 binomial mask: only the center is filtered
    load_setup(3, 3, 3, 3, RST_WEIGHTS, RST_WEIGHTS);
    rows = '{
      '{8'd0,   1'b0, 1'b0, '0},
      '{8'd255, 1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b0, '0},
      '{8'd128, 1'b0, 1'b0, '0},
      '{8'd77,  1'b0, 1'b1, '{8'd0,   1'b0, 1'b0}},
      '{8'd254, 1'b0, 1'b1, '{8'd255, 1'b0, 1'b0}},
      '{8'd7,   1'b0, 1'b1, '{8'd1,   1'b0, 1'b0}},
      '{8'd8,   1'b0, 1'b1, '{8'd128, 1'b0, 1'b0}},
      '{8'd255, 1'b0, 1'b0, '0},
      '{8'd0,   1'b1, 1'b1, '{8'd254, 1'b0, 1'b0}},
      '{8'd0,   1'b1, 1'b1, '{8'd7,   1'b0, 1'b0}},
      '{8'd0,   1'b1, 1'b1, '{8'd8,   1'b0, 1'b0}},
      '{8'd0,   1'b1, 1'b1, '{8'd255, 1'b1, 1'b0}},
      '{8'hFF,  1'b1, 1'b0, '0}
    };
    foreach (rows[i]) begin
      it.pixel_in = rows[i].pix;
      it.is_flush = rows[i].flush;
      send_pixel(it, rows[i].typed, rows[i].res);
    end
    push <= 1'b0;
    wait_idle();

    phase = 0;
    while (rand_sent < RAND_ITEMS || phase < 8) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      idle_on = ($urandom_range(0, 3) != 0);
      case (phase)
        0: load_setup(w, h, 7, 7, '0, random_weights(0));          // zero total weight
        1: load_setup(w, h, 7, 7, {7{8'hFF}}, {7{8'hFF}});
        2: load_setup(0, 0, 0, 0, random_weights(0), random_weights(0));
        3: load_setup(w, h, 6, 4, random_weights(1), random_weights(1)); // even sizes
        4: begin
          idle_on = 1'b0;
          load_setup(12'hFFF, 1, 1, 1, random_weights(0), random_weights(0));
        end
        5: begin
          idle_on = 1'b0;
          load_setup(1, h, 3, 1, random_weights(0), random_weights(0));
        end
        6: load_setup(w, h, 1, 1, random_weights(1), random_weights(1));
        default: load_setup($urandom_range(0, 12), $urandom_range(0, 10),
                            $urandom_range(0, 7), $urandom_range(0, 7),
                            random_weights(1), random_weights(1));
      endcase
      n_frames = $urandom_range(1, 2);
      n_pix = (phase == 4) ? 40 : n_frames * frame_w() * frame_h();
      for (int p = 0; p < n_pix; p++) begin
        it.pixel_in = PIX_W'($urandom_range(0, 255));
        it.is_flush = 1'b0;
        send_pixel(it);
        rand_sent++;
      end
      if (phase == 4) begin
        // clamped width runs on part of a line; a one-pixel line brings the counters back to 0
        push <= 1'b0;
        wait_idle();
        load_setup(1, 1, 1, 1, m_colw, m_roww);
        it.pixel_in = PIX_W'($urandom_range(0, 255));
        it.is_flush = 1'b0;
        send_pixel(it);
        rand_sent++;
      end
      extra = backlog + $urandom_range(0, 2);
      for (int k = 0; k < extra; k++) begin
        it.pixel_in = PIX_W'($urandom_range(0, 255));
        it.is_flush = 1'b1;
        send_pixel(it);
      end
      push <= 1'b0;
      wait_idle();
      phase++;
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
